// ===== hw/rtl/cgnpm_pkg.sv =====
// Shared types and constants of the class gated nearest point matcher.
// No dependencies; imported by the top level.
package cgnpm_pkg;

   // Field widths
   localparam int unsigned COORD_W    = 16;
   localparam int unsigned CLASS_W    = 8;
   localparam int unsigned QUERY_W    = 10;
   localparam int unsigned OPCODE_W   = 2;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned OUT_IDX_W  = 10;

   // Reference table word: {class, y, x}
   localparam int unsigned REF_WORD_W = CLASS_W + 2 * COORD_W;

   // Squared distances: two 32 bit squares summed
   localparam int unsigned SQ_W   = 2 * COORD_W;
   localparam int unsigned DIST_W = SQ_W + 1;

   // Square root unit: one result bit per step
   localparam int unsigned ROOT_STEPS = COORD_W;
   localparam int unsigned STEP_W     = $clog2(ROOT_STEPS);
   localparam int unsigned REM_W      = COORD_W + 2;

   // Defaults
   localparam int unsigned MAX_REFERENCES_DEFAULT = 1024;
   localparam logic [CSR_DATA_W-1:0] LIMIT_RESET  = 16'd1120;
   localparam logic [CSR_DATA_W-1:0] FRAME_RESET  = 16'd0;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DISTANCE_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_TAG      = 2'd1;

   // Sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_ROOT = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

endpackage

// ===== hw/rtl/class_gated_nearest_point_match.sv =====
// Class gated nearest point matcher: reference table, scan pipeline, square root.
// Depends on cgnpm_pkg and cgnpm_ram.
//
// Use: each req beat carries an opcode. Clear empties the reference table,
// append stores one point with its class tag (ignored once the table is full),
// query looks for the nearest reference point of the same class. Clear and
// append finish in the accepting cycle. A query reads the table one entry
// per cycle from the reference RAM's single read port into the scan pipeline,
// then, if it found a candidate, runs the square root steps and loads the
// output register; while it does so req_ready is low. A query whose best
// distance is strictly below distance_limit gives one rsp beat; otherwise it
// gives none. The result waits in an output register, so a new req beat is
// taken while an earlier rsp beat is stalled; a later query that finishes
// first waits in its last state until the output register is free.
// Reset empties the table (entry bits stay undefined until appended), sets
// distance_limit to 70.0 px and frame_tag to 0. The csr port writes a
// register; the user must write it only while the block is idle, which the
// block itself does not enforce.
module class_gated_nearest_point_match #(
   parameter int unsigned MAX_REFERENCES = cgnpm_pkg::MAX_REFERENCES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [cgnpm_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [cgnpm_pkg::COORD_W-1:0]       req_pos_x,
   input  logic [cgnpm_pkg::COORD_W-1:0]       req_pos_y,
   input  logic [cgnpm_pkg::CLASS_W-1:0]       req_class_tag,
   input  logic [cgnpm_pkg::QUERY_W-1:0]       req_query_number,
   // Response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cgnpm_pkg::OUT_IDX_W-1:0]     rsp_reference_index,
   output logic [cgnpm_pkg::QUERY_W-1:0]       rsp_matched_query,
   output logic [cgnpm_pkg::CSR_DATA_W-1:0]    rsp_frame_id,
   output logic [cgnpm_pkg::COORD_W-1:0]       rsp_match_distance,
   // Register write port
   input  logic                                csr_write_en,
   input  logic [cgnpm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cgnpm_pkg::CSR_DATA_W-1:0]    csr_data
);

   import cgnpm_pkg::*;

   localparam int unsigned IDX_W  = $clog2(MAX_REFERENCES);
   localparam int unsigned CNT_W  = $clog2(MAX_REFERENCES + 1);
   localparam int unsigned WIDE_W = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;

   // Registers
   logic [CSR_DATA_W-1:0] limit_ff, limit_in;
   logic [CSR_DATA_W-1:0] frame_ff, frame_in;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      issue_ff, issue_in;

   logic [COORD_W-1:0]    qx_ff, qx_in;
   logic [COORD_W-1:0]    qy_ff, qy_in;
   logic [CLASS_W-1:0]    qcls_ff, qcls_in;
   logic [QUERY_W-1:0]    qnum_ff, qnum_in;

   logic                  v1_ff, v1_in;
   logic [IDX_W-1:0]      idx1_ff, idx1_in;
   logic                  hit2_ff, hit2_in;
   logic [IDX_W-1:0]      idx2_ff, idx2_in;
   logic [COORD_W-1:0]    dx_ff, dx_in;
   logic [COORD_W-1:0]    dy_ff, dy_in;
   logic                  hit3_ff, hit3_in;
   logic [IDX_W-1:0]      idx3_ff, idx3_in;
   logic [SQ_W-1:0]       sqx_ff, sqx_in;
   logic [SQ_W-1:0]       sqy_ff, sqy_in;

   logic [DIST_W-1:0]     best_ff, best_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic                  found_ff, found_in;

   logic [SQ_W-1:0]       rad_ff, rad_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [COORD_W-1:0]    root_ff, root_in;
   logic [STEP_W-1:0]     step_ff, step_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic [QUERY_W-1:0]    out_qnum_ff, out_qnum_in;
   logic [CSR_DATA_W-1:0] out_frame_ff, out_frame_in;
   logic [COORD_W-1:0]    out_dist_ff, out_dist_in;

   // Combinational helpers
   logic                  req_fire;
   logic                  issuing;
   logic                  pipe_busy;
   logic                  out_free;
   logic                  wr_en;
   logic [REF_WORD_W-1:0] wr_word;
   logic [REF_WORD_W-1:0] rd_word;
   logic [COORD_W-1:0]    ref_x;
   logic [COORD_W-1:0]    ref_y;
   logic [CLASS_W-1:0]    ref_cls;
   logic [DIST_W-1:0]     d2;
   logic [SQ_W-1:0]       limit_sq;
   logic [REM_W+1:0]      rem_shift;
   logic [REM_W+1:0]      rem_test;
   logic [WIDE_W-1:0]     best_idx_wide;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign issuing   = (state_ff == ST_SCAN) && (issue_ff < count_ff);
   assign pipe_busy = v1_ff || hit2_ff || hit3_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Append writes the entry at the fill count
   assign wr_en   = req_fire && (req_opcode == OP_APPEND)
                    && (count_ff < CNT_W'(MAX_REFERENCES));
   assign wr_word = {req_class_tag, req_pos_y, req_pos_x};

   cgnpm_ram #(
      .WIDTH (REF_WORD_W),
      .DEPTH (MAX_REFERENCES)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_word),
      .rd_en   (issuing),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_word)
   );

   assign ref_x   = rd_word[COORD_W-1:0];
   assign ref_y   = rd_word[2*COORD_W-1:COORD_W];
   assign ref_cls = rd_word[REF_WORD_W-1:2*COORD_W];

   assign limit_sq  = {{COORD_W{1'b0}}, limit_ff} * {{COORD_W{1'b0}}, limit_ff};
   assign d2        = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign rem_shift = {rem_ff, rad_ff[SQ_W-1:SQ_W-2]};
   assign rem_test  = {2'b00, root_ff, 2'b01};

   assign best_idx_wide = WIDE_W'(best_idx_ff);

   // Configuration registers
   always_comb begin
      limit_in = limit_ff;
      frame_in = frame_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_DISTANCE_LIMIT: limit_in = csr_data;
            REG_FRAME_TAG:      frame_in = csr_data;
            default:            ;
         endcase
      end
   end

   // Scan pipeline: RAM data -> abs differences -> squares -> compare
   always_comb begin
      v1_in   = issuing;
      idx1_in = issue_ff[IDX_W-1:0];

      hit2_in = v1_ff && (ref_cls == qcls_ff);
      idx2_in = idx1_ff;
      dx_in   = (qx_ff > ref_x) ? (qx_ff - ref_x) : (ref_x - qx_ff);
      dy_in   = (qy_ff > ref_y) ? (qy_ff - ref_y) : (ref_y - qy_ff);

      hit3_in = hit2_ff;
      idx3_in = idx2_ff;
      sqx_in  = {{COORD_W{1'b0}}, dx_ff} * {{COORD_W{1'b0}}, dx_ff};
      sqy_in  = {{COORD_W{1'b0}}, dy_ff} * {{COORD_W{1'b0}}, dy_ff};
   end

   // Sequencer, best candidate tracking and square root steps
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      issue_in    = issue_ff;
      qx_in       = qx_ff;
      qy_in       = qy_ff;
      qcls_in     = qcls_ff;
      qnum_in     = qnum_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      found_in    = found_ff;
      rad_in      = rad_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      step_in     = step_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_idx_in   = out_idx_ff;
      out_qnum_in  = out_qnum_ff;
      out_frame_in = out_frame_ff;
      out_dist_in  = out_dist_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_opcode)
                  OP_CLEAR: count_in = '0;
                  OP_APPEND: begin
                     if (wr_en) begin
                        count_in = CNT_W'(count_ff + 1'b1);
                     end
                  end
                  OP_QUERY: begin
                     qx_in    = req_pos_x;
                     qy_in    = req_pos_y;
                     qcls_in  = req_class_tag;
                     qnum_in  = req_query_number;
                     best_in  = {1'b0, limit_sq};
                     found_in = 1'b0;
                     issue_in = '0;
                     state_in = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (issuing) begin
               issue_in = CNT_W'(issue_ff + 1'b1);
            end
            // strict less keeps the lowest index on ties
            if (hit3_ff && (d2 < best_ff)) begin
               best_in     = d2;
               best_idx_in = idx3_ff;
               found_in    = 1'b1;
            end
            if (!issuing && !pipe_busy) begin
               if (found_ff) begin
                  rad_in   = best_ff[SQ_W-1:0];
                  rem_in   = '0;
                  root_in  = '0;
                  step_in  = STEP_W'(ROOT_STEPS - 1);
                  state_in = ST_ROOT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ROOT: begin
            // restoring square root, one result bit per cycle
            rad_in = {rad_ff[SQ_W-3:0], 2'b00};
            if (rem_shift >= rem_test) begin
               rem_in  = REM_W'(rem_shift - rem_test);
               root_in = {root_ff[COORD_W-2:0], 1'b1};
            end else begin
               rem_in  = REM_W'(rem_shift);
               root_in = {root_ff[COORD_W-2:0], 1'b0};
            end
            step_in = STEP_W'(step_ff - 1'b1);
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_idx_in   = best_idx_wide[OUT_IDX_W-1:0];
               out_qnum_in  = qnum_ff;
               out_frame_in = frame_ff;
               out_dist_in  = root_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         frame_ff     <= FRAME_RESET;
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         v1_ff        <= 1'b0;
         hit2_ff      <= 1'b0;
         hit3_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         frame_ff     <= frame_in;
         state_ff     <= state_in;
         count_ff     <= count_in;
         v1_ff        <= v1_in;
         hit2_ff      <= hit2_in;
         hit3_ff      <= hit3_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      issue_ff     <= issue_in;
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      qcls_ff      <= qcls_in;
      qnum_ff      <= qnum_in;
      idx1_ff      <= idx1_in;
      idx2_ff      <= idx2_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      idx3_ff      <= idx3_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      rad_ff       <= rad_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      step_ff      <= step_in;
      out_idx_ff   <= out_idx_in;
      out_qnum_ff  <= out_qnum_in;
      out_frame_ff <= out_frame_in;
      out_dist_ff  <= out_dist_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_reference_index = out_idx_ff;
   assign rsp_matched_query   = out_qnum_ff;
   assign rsp_frame_id        = out_frame_ff;
   assign rsp_match_distance  = out_dist_ff;

`ifndef SYNTHESIS
   // Fill count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_REFERENCES))
      else $error("reference count above table depth");

   // Scan pipeline only carries beats while scanning
   a_pipe_in_scan: assert property (@(posedge clock) disable iff (reset)
      pipe_busy |-> (state_ff == ST_SCAN))
      else $error("scan pipeline active outside scan");

   // A found best distance lies below the squared limit, so fits the root input
   a_best_fits: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (best_ff[DIST_W-1] == 1'b0))
      else $error("best squared distance out of range");

   // Root and output states are only reached with a candidate
   a_root_found: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ROOT) || (state_ff == ST_DONE)) |-> found_ff)
      else $error("square root without a candidate");

   // Leaving the scan without a candidate returns to idle
   a_scan_exit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && !issuing && !pipe_busy && !found_ff)
         |=> (state_ff == ST_IDLE))
      else $error("empty scan did not return to idle");
`endif

endmodule

// ===== hw/rtl/cgnpm_ram.sv =====
// Generic simple dual port RAM: one write port, one registered read port.
// No dependencies.
module cgnpm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
